// ===== hdl/fqs_pkg.sv =====
`timescale 1ns / 1ps

package fqs_pkg;

    // Default sizing of the queue.
    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // Fixed widths of the beat fields.
    localparam int ACTION_W    = 2;
    localparam int VALUE_W     = 32;
    localparam int OCCUPANCY_W = 5;

    // Action codes of an input beat.
    typedef enum logic [ACTION_W-1:0] {
        ACT_ENQ  = 2'd0,
        ACT_DEQ  = 2'd1,
        ACT_CLR  = 2'd2,
        ACT_SRCH = 2'd3
    } t_action;

    // Operation broadcast from the top level to every cell.
    typedef struct packed {
        logic enq;
        logic deq;
        logic clr;
    } t_cell_ctrl;

endpackage

// ===== hdl/fqs_in_if.sv =====
`timescale 1ns / 1ps

interface fqs_in_if;

    logic                               valid;
    logic                               ready;
    fqs_pkg::t_action                   action;
    logic signed [fqs_pkg::VALUE_W-1:0] value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);

endinterface

// ===== hdl/fqs_out_if.sv =====
`timescale 1ns / 1ps

interface fqs_out_if;

    logic                                   valid;
    logic                                   ready;
    logic signed [fqs_pkg::VALUE_W-1:0]     out_value;
    logic                                   found;
    logic                                   is_empty;
    logic                                   is_full;
    logic                                   underflow;
    logic                                   overflow;
    logic        [fqs_pkg::OCCUPANCY_W-1:0] occupancy;
    logic signed [fqs_pkg::VALUE_W-1:0]     head_value;
    logic signed [fqs_pkg::VALUE_W-1:0]     tail_value;

    modport source (
        output valid, output out_value, output found, output is_empty,
        output is_full, output underflow, output overflow, output occupancy,
        output head_value, output tail_value, input ready
    );
    modport sink (
        input valid, input out_value, input found, input is_empty,
        input is_full, input underflow, input overflow, input occupancy,
        input head_value, input tail_value, output ready
    );

endinterface

// ===== hdl/fqs_cell.sv =====
`timescale 1ns / 1ps

module fqs_cell #(
    parameter int DATA_WIDTH = fqs_pkg::DATA_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  fqs_pkg::t_cell_ctrl   i_ctrl,
    input  logic [DATA_WIDTH-1:0] i_key,
    input  logic                  i_prev_valid,
    input  logic                  i_next_valid,
    input  logic [DATA_WIDTH-1:0] i_next_data,
    output logic                  o_valid,
    output logic [DATA_WIDTH-1:0] o_data,
    output logic                  o_match
);

    logic                  r_valid;
    logic                  n_valid;
    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;

    // The first free cell behind a valid one takes an enqueued value,
    // a dequeue shifts every cell one place toward the head, a clear empties every cell.
    always_comb begin
        n_valid = r_valid;
        n_data  = r_data;
        if (i_ctrl.clr) begin
            n_valid = 1'b0;
        end else if (i_ctrl.deq) begin
            n_valid = i_next_valid;
            n_data  = i_next_data;
        end else if (i_ctrl.enq && !r_valid && i_prev_valid) begin
            n_valid = 1'b1;
            n_data  = i_key;
        end
    end

    // Occupancy flag of the cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Stored value.
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    // Local comparison against the search key.
    assign o_match = r_valid && (r_data == i_key);
    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== hdl/fifo_queue_with_search.sv =====
`timescale 1ns / 1ps
// Latency: a result beat appears in the cycle after its input beat is taken.
// Throughput: one beat per cycle for every action unless the receiver stalls;
// the search compares the key in all cells of the chain at once and the output
// register decouples the two sides. Reset clears every cell flag, the count, the
// tail register and the output valid flag, so the queue starts empty.

module fifo_queue_with_search #(
    parameter int DEPTH      = fqs_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = fqs_pkg::DATA_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fqs_in_if.sink    i_in,
    fqs_out_if.source o_out
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int VW    = fqs_pkg::VALUE_W;

    logic                  cell_valid [DEPTH];
    logic [DATA_WIDTH-1:0] cell_data  [DEPTH];
    logic [DEPTH-1:0]      cell_match;

    logic                  accept;
    fqs_pkg::t_cell_ctrl   ctrl;
    logic [63:0]           key_ext;
    logic [DATA_WIDTH-1:0] key;
    logic [63:0]           key_out_ext;
    logic [63:0]           head_ext;
    logic [63:0]           second_ext;
    logic                  is_empty;
    logic                  is_full;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [VW-1:0]    r_tail;
    logic [VW-1:0]    n_tail;

    logic                           r_out_valid;
    logic [VW-1:0]                  r_out_value;
    logic [VW-1:0]                  n_out_value;
    logic                           r_found;
    logic                           n_found;
    logic                           r_underflow;
    logic                           n_underflow;
    logic                           r_overflow;
    logic                           n_overflow;
    logic [VW-1:0]                  r_head;
    logic [VW-1:0]                  n_head;

    // Input handshake: a new beat is taken whenever the output slot frees.
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    // The key keeps its low DATA_WIDTH bits, sign-extended back for output.
    assign key_ext     = 64'($signed(i_in.value));
    assign key         = key_ext[DATA_WIDTH-1:0];
    assign key_out_ext = 64'($signed(key));
    assign head_ext    = 64'($signed(cell_data[0]));
    assign second_ext  = 64'($signed(cell_data[1]));

    assign is_empty = !cell_valid[0];
    assign is_full  = cell_valid[DEPTH-1];

    // Operation broadcast to the chain.
    always_comb begin
        ctrl.enq = accept && (i_in.action == fqs_pkg::ACT_ENQ);
        ctrl.deq = accept && (i_in.action == fqs_pkg::ACT_DEQ);
        ctrl.clr = accept && (i_in.action == fqs_pkg::ACT_CLR);
    end

    // Chain of cells, cell 0 at the head.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic                  prev_valid;
        logic                  next_valid;
        logic [DATA_WIDTH-1:0] next_data;

        if (g == 0) begin : g_first
            assign prev_valid = 1'b1;
        end else begin : g_rest
            assign prev_valid = cell_valid[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign next_valid = 1'b0;
            assign next_data  = cell_data[g];
        end else begin : g_inner
            assign next_valid = cell_valid[g+1];
            assign next_data  = cell_data[g+1];
        end

        fqs_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (ctrl),
            .i_key        (key),
            .i_prev_valid (prev_valid),
            .i_next_valid (next_valid),
            .i_next_data  (next_data),
            .o_valid      (cell_valid[g]),
            .o_data       (cell_data[g]),
            .o_match      (cell_match[g])
        );
    end

    // Result of the accepted beat and the queue status after it.
    always_comb begin
        n_count     = r_count;
        n_tail      = r_tail;
        n_out_value = '0;
        n_found     = 1'b0;
        n_underflow = 1'b0;
        n_overflow  = 1'b0;
        n_head      = is_empty ? '0 : head_ext[VW-1:0];
        case (i_in.action)
            fqs_pkg::ACT_ENQ: begin
                if (is_full) begin
                    n_overflow = 1'b1;
                end else begin
                    n_count = r_count + CNT_W'(1);
                    n_tail  = key_out_ext[VW-1:0];
                    if (is_empty) begin
                        n_head = key_out_ext[VW-1:0];
                    end
                end
            end
            fqs_pkg::ACT_DEQ: begin
                if (is_empty) begin
                    n_underflow = 1'b1;
                end else begin
                    n_out_value = head_ext[VW-1:0];
                    n_count     = r_count - CNT_W'(1);
                    n_head      = cell_valid[1] ? second_ext[VW-1:0] : '0;
                    if (r_count == CNT_W'(1)) begin
                        n_tail = '0;
                    end
                end
            end
            fqs_pkg::ACT_CLR: begin
                n_count = '0;
                n_tail  = '0;
                n_head  = '0;
            end
            fqs_pkg::ACT_SRCH: begin
                n_found = |cell_match;
            end
            default: begin
                n_found = 1'b0;
            end
        endcase
    end

    // Count, tail and output beat valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_tail      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_tail      <= n_tail;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_value <= n_out_value;
            r_found     <= n_found;
            r_underflow <= n_underflow;
            r_overflow  <= n_overflow;
            r_head      <= n_head;
        end
    end

    // Status fields follow the count and tail registers directly.
    assign o_out.valid      = r_out_valid;
    assign o_out.out_value  = r_out_value;
    assign o_out.found      = r_found;
    assign o_out.is_empty   = (r_count == '0);
    assign o_out.is_full    = (r_count == CNT_W'(DEPTH));
    assign o_out.underflow  = r_underflow;
    assign o_out.overflow   = r_overflow;
    assign o_out.occupancy  = fqs_pkg::OCCUPANCY_W'(r_count);
    assign o_out.head_value = r_head;
    assign o_out.tail_value = r_tail;

endmodule

// ===== test/fifo_queue_with_search_tb.sv =====
`timescale 1ns / 1ps

module fifo_queue_with_search_tb;

    localparam int CYCLE_LIMIT    = 600000;
    localparam int RX_HOLD_CYCLES = 60;
    localparam int PHASE_COUNT    = 17;
    localparam int PHASE_BEATS    = 100;
    localparam int POOL_SIZE      = 32;

    // Status fields of one result beat.
    typedef struct packed {
        logic signed [fqs_pkg::VALUE_W-1:0]     out_value;
        logic                                   found;
        logic                                   is_empty;
        logic                                   is_full;
        logic                                   underflow;
        logic                                   overflow;
        logic        [fqs_pkg::OCCUPANCY_W-1:0] occupancy;
        logic signed [fqs_pkg::VALUE_W-1:0]     head_value;
        logic signed [fqs_pkg::VALUE_W-1:0]     tail_value;
    } t_status;

    // Keeps its own copy of the queue and the status beats still owed by the block.
    class queue_status_board;
        logic signed [fqs_pkg::VALUE_W-1:0] held[$];
        t_status                            owed[$];
        int                                 error_count = 0;

        // Apply one accepted action to the queue copy and note the status it yields.
        function void note_action(fqs_pkg::t_action act,
                                  logic signed [fqs_pkg::VALUE_W-1:0] val);
            t_status s;
            s = '0;
            case (act)
                fqs_pkg::ACT_ENQ: begin
                    if (held.size() >= fqs_pkg::DEPTH_DEF) s.overflow = 1'b1;
                    else held.push_back(val);
                end
                fqs_pkg::ACT_DEQ: begin
                    if (held.size() == 0) s.underflow = 1'b1;
                    else s.out_value = held.pop_front();
                end
                fqs_pkg::ACT_CLR: begin
                    held.delete();
                end
                default: begin
                    foreach (held[i]) if (held[i] == val) s.found = 1'b1;
                end
            endcase
            s.occupancy = fqs_pkg::OCCUPANCY_W'(held.size());
            s.is_empty  = (held.size() == 0);
            s.is_full   = (held.size() == fqs_pkg::DEPTH_DEF);
            if (held.size() > 0) begin
                s.head_value = held[0];
                s.tail_value = held[$];
            end
            owed.push_back(s);
        endfunction

        function void compare_field(string name, logic [fqs_pkg::VALUE_W-1:0] want,
                                    logic [fqs_pkg::VALUE_W-1:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, actual %0h", name, want, got);
                error_count++;
            end
        endfunction

        // Match a result beat against the oldest owed status.
        function void check_status(t_status got);
            t_status want;
            if (owed.size() == 0) begin
                $error("result beat arrived with no expected status waiting");
                error_count++;
                return;
            end
            want = owed.pop_front();
            compare_field("out_value", want.out_value, got.out_value);
            compare_field("found", want.found, got.found);
            compare_field("is_empty", want.is_empty, got.is_empty);
            compare_field("is_full", want.is_full, got.is_full);
            compare_field("underflow", want.underflow, got.underflow);
            compare_field("overflow", want.overflow, got.overflow);
            compare_field("occupancy", want.occupancy, got.occupancy);
            compare_field("head_value", want.head_value, got.head_value);
            compare_field("tail_value", want.tail_value, got.tail_value);
        endfunction

        function int pending();
            return owed.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    fqs_in_if  in_if ();
    fqs_out_if out_if ();

    fifo_queue_with_search uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    queue_status_board                  board = new();
    logic signed [fqs_pkg::VALUE_W-1:0] sent_pool[$];
    bit                                 tx_steady   = 1'b0;
    bit                                 rx_steady   = 1'b0;
    bit                                 rx_hold_req = 1'b0;
    int unsigned                        cycle_count = 0;

    always #5 i_clk = ~i_clk;

    // Give up on a hung run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    // Extremes, reused values, or a fully random word.
    function automatic logic signed [fqs_pkg::VALUE_W-1:0] pick_value();
        int unsigned r;
        r = $urandom_range(0, 15);
        if (r == 0) return 32'sh7FFF_FFFF;
        if (r == 1) return 32'sh8000_0000;
        if (r == 2) return 32'sd0;
        if (r == 3) return -32'sd1;
        if (r < 8 && sent_pool.size() > 0)
            return sent_pool[$urandom_range(0, sent_pool.size() - 1)];
        return $urandom;
    endfunction

    // Offer one input beat, hold it until taken, then maybe idle a while.
    task automatic send_beat(input fqs_pkg::t_action act,
                             input logic signed [fqs_pkg::VALUE_W-1:0] val);
        in_if.valid  <= 1'b1;
        in_if.action <= act;
        in_if.value  <= val;
        @(posedge i_clk);
        while (in_if.ready !== 1'b1) @(posedge i_clk);
        if (act == fqs_pkg::ACT_ENQ) begin
            sent_pool.push_back(val);
            if (sent_pool.size() > POOL_SIZE) void'(sent_pool.pop_front());
        end
        if (!tx_steady && $urandom_range(0, 2) == 0) begin
            in_if.valid <= 1'b0;
            repeat (gap_len()) @(posedge i_clk);
        end
    endtask

    // One random beat; style 0 fills the queue, 1 drains it, 2 keeps it level.
    task automatic send_random_beat(input int style);
        int unsigned r;
        int unsigned enq_w;
        int unsigned deq_w;
        r     = $urandom_range(0, 99);
        enq_w = (style == 0) ? 60 : (style == 1) ? 15 : 40;
        deq_w = (style == 0) ? 15 : (style == 1) ? 60 : 35;
        if (r < 2) begin
            send_beat(fqs_pkg::ACT_CLR, $urandom);
        end else if (r < 2 + enq_w) begin
            send_beat(fqs_pkg::ACT_ENQ, pick_value());
        end else if (r < 2 + enq_w + deq_w) begin
            send_beat(fqs_pkg::ACT_DEQ, $urandom);
        end else if (sent_pool.size() > 0 && $urandom_range(0, 1) == 0) begin
            send_beat(fqs_pkg::ACT_SRCH,
                      sent_pool[$urandom_range(0, sent_pool.size() - 1)]);
        end else begin
            send_beat(fqs_pkg::ACT_SRCH, pick_value());
        end
    endtask

    // Receiver side: random stalls, plus a long hold-off on request.
    initial begin : rx_side
        int unsigned stall_left;
        stall_left   = 0;
        out_if.ready = 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (rx_hold_req) begin
                out_if.ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
                rx_hold_req = 1'b0;
                out_if.ready <= 1'b1;
            end else if (stall_left > 0) begin
                out_if.ready <= 1'b0;
                stall_left--;
            end else begin
                out_if.ready <= 1'b1;
                if (!rx_steady && $urandom_range(0, 3) == 0) stall_left = gap_len();
            end
            @(posedge i_clk);
        end
    end

    // Watch both channels; the result beat is checked before the new input is noted.
    always @(posedge i_clk) begin : watch_beats
        t_status got;
        if (i_rst_n === 1'b1) begin
            if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
                got.out_value  = out_if.out_value;
                got.found      = out_if.found;
                got.is_empty   = out_if.is_empty;
                got.is_full    = out_if.is_full;
                got.underflow  = out_if.underflow;
                got.overflow   = out_if.overflow;
                got.occupancy  = out_if.occupancy;
                got.head_value = out_if.head_value;
                got.tail_value = out_if.tail_value;
                board.check_status(got);
            end
            if (in_if.valid === 1'b1 && in_if.ready === 1'b1)
                board.note_action(in_if.action, in_if.value);
        end
    end

    initial begin : stimulus
        int i;
        int phase;
        i_rst_n      = 1'b0;
        in_if.valid  = 1'b0;
        in_if.action = fqs_pkg::ACT_ENQ;
        in_if.value  = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: actions on an empty queue, extremes, filling past full.
        send_beat(fqs_pkg::ACT_DEQ, 32'sd5);
        send_beat(fqs_pkg::ACT_CLR, -32'sd1);
        send_beat(fqs_pkg::ACT_SRCH, 32'sd0);
        send_beat(fqs_pkg::ACT_ENQ, 32'sh7FFF_FFFF);
        send_beat(fqs_pkg::ACT_ENQ, 32'sh8000_0000);
        send_beat(fqs_pkg::ACT_ENQ, 32'sd0);
        send_beat(fqs_pkg::ACT_ENQ, -32'sd1);
        send_beat(fqs_pkg::ACT_ENQ, 32'sh5555_5555);
        send_beat(fqs_pkg::ACT_ENQ, 32'shAAAA_AAAA);
        for (i = 6; i < fqs_pkg::DEPTH_DEF; i++) send_beat(fqs_pkg::ACT_ENQ, $urandom);
        // The dropped value must not turn up in a search.
        send_beat(fqs_pkg::ACT_ENQ, 32'sh1234_5678);
        send_beat(fqs_pkg::ACT_SRCH, 32'sh8000_0000);
        send_beat(fqs_pkg::ACT_SRCH, 32'sh1234_5678);
        send_beat(fqs_pkg::ACT_DEQ, 32'sd0);
        send_beat(fqs_pkg::ACT_CLR, 32'sd0);
        send_beat(fqs_pkg::ACT_DEQ, 32'sd0);

        // Random phases alternating between filling, draining and steady use.
        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            tx_steady = (phase % 5 == 4) || (phase == 6);
            rx_steady = (phase % 5 == 4);
            if (phase == 6) rx_hold_req = 1'b1;
            repeat (PHASE_BEATS) send_random_beat(phase % 3);
        end
        in_if.valid <= 1'b0;
        rx_steady = 1'b0;

        // Let the watcher note the last accepted beat before draining.
        @(posedge i_clk);
        while (board.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (board.error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/fqs_pkg.sv
hdl/fqs_in_if.sv
hdl/fqs_out_if.sv
hdl/fqs_cell.sv
hdl/fifo_queue_with_search.sv
test/fifo_queue_with_search_tb.sv
